[hw/rtl/tevq_pkg.sv]
// tevq_pkg: shared types and constants for the timed event priority queue
// used by tevq_cell and timed_event_priority_queue; no dependencies

package tevq_pkg;

    // default configuration
    localparam int DEPTH_DEF     = 64;
    localparam int TIME_BITS_DEF = 32;

    // fixed field widths
    localparam int PID_W      = 8;
    localparam int IN_TIME_W  = 32;
    localparam int OUT_TIME_W = 32;
    localparam int ENTRIES_W  = 7;
    localparam int STATUS_W   = 2;

    // function codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_TAKE   = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_TAKEN    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic ins;   // insert this cycle (queue not full)
        logic take;  // take this cycle (queue not empty)
        logic swap;  // take the second entry instead of the first
    } t_cell_ctrl;

endpackage

[hw/rtl/tevq_cell.sv]
// tevq_cell: one slot of the sorted event chain
// depends on tevq_pkg; takes an entry from the left neighbor on insert or the right one on take

module tevq_cell #(
    parameter int IDX       = 0,
    parameter int TIME_BITS = tevq_pkg::TIME_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tevq_pkg::t_cell_ctrl        i_ctrl,
    input  logic [TIME_BITS-1:0]        i_new_time,
    input  logic [tevq_pkg::PID_W-1:0]  i_new_pid,
    input  logic                        i_new_core,
    input  logic                        i_prev_ge,
    input  logic                        i_prev_valid,
    input  logic [TIME_BITS-1:0]        i_prev_time,
    input  logic [tevq_pkg::PID_W-1:0]  i_prev_pid,
    input  logic                        i_prev_core,
    input  logic                        i_next_valid,
    input  logic [TIME_BITS-1:0]        i_next_time,
    input  logic [tevq_pkg::PID_W-1:0]  i_next_pid,
    input  logic                        i_next_core,
    output logic                        o_ge,
    output logic                        o_valid,
    output logic [TIME_BITS-1:0]        o_time,
    output logic [tevq_pkg::PID_W-1:0]  o_pid,
    output logic                        o_core
);
    import tevq_pkg::*;

    logic                 r_valid, n_valid;
    logic [TIME_BITS-1:0] r_time, n_time;
    logic [PID_W-1:0]     r_pid, n_pid;
    logic                 r_core, n_core;
    logic                 w_ge;
    logic                 w_shl;

    // new word goes at or before this slot when the slot is empty or not earlier
    assign w_ge = !(r_valid && (r_time < i_new_time));

    // slots from the taken position onward pull from the right
    assign w_shl = i_ctrl.take && ((IDX != 0) || !i_ctrl.swap);

    // next slot contents
    always_comb begin
        n_valid = r_valid;
        n_time  = r_time;
        n_pid   = r_pid;
        n_core  = r_core;
        if (i_ctrl.ins) begin
            if (i_prev_ge) begin
                n_valid = i_prev_valid;
                n_time  = i_prev_time;
                n_pid   = i_prev_pid;
                n_core  = i_prev_core;
            end else if (w_ge) begin
                n_valid = 1'b1;
                n_time  = i_new_time;
                n_pid   = i_new_pid;
                n_core  = i_new_core;
            end
        end else if (w_shl) begin
            n_valid = i_next_valid;
            n_time  = i_next_time;
            n_pid   = i_next_pid;
            n_core  = i_next_core;
        end
    end

    // valid bit under reset, payload free running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time <= n_time;
        r_pid  <= n_pid;
        r_core <= n_core;
    end

    assign o_ge    = w_ge;
    assign o_valid = r_valid;
    assign o_time  = r_time;
    assign o_pid   = r_pid;
    assign o_core  = r_core;

endmodule

[hw/rtl/timed_event_priority_queue.sv]
// timed_event_priority_queue: top level, a chain of DEPTH tevq_cell slots
// depends on tevq_pkg and tevq_cell

// Sorted event queue holding up to DEPTH events in ascending time order,
// newest first among equal times. Each command (insert or take) is applied
// to every slot of the cell chain in the same clock edge at which it is
// accepted, so a command is taken every cycle and busy stays low. The
// result word appears on the o_ ports with o_done high for exactly one
// cycle, in the cycle after the command is accepted; it is never held back,
// so the receiver must take it in that cycle. A take returns the front
// event, or the second one when both share a time and only the second is a
// core event. The result word is registered behind the chain's compare and
// shift logic.

module timed_event_priority_queue #(
    parameter int DEPTH     = tevq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = tevq_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_func,
    input  logic [tevq_pkg::PID_W-1:0]        i_proc_id,
    input  logic [tevq_pkg::IN_TIME_W-1:0]    i_event_time,
    input  logic                              i_is_core,
    output logic                              o_done,
    output logic [tevq_pkg::STATUS_W-1:0]     o_status,
    output logic [tevq_pkg::PID_W-1:0]        o_out_proc_id,
    output logic [tevq_pkg::OUT_TIME_W-1:0]   o_out_time,
    output logic [tevq_pkg::ENTRIES_W-1:0]    o_entries,
    output logic                              o_list_empty
);
    import tevq_pkg::*;

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int EW  = (CW > ENTRIES_W) ? CW : ENTRIES_W;
    localparam int XIW = (TIME_BITS > IN_TIME_W) ? TIME_BITS : IN_TIME_W;
    localparam int XOW = (TIME_BITS > OUT_TIME_W) ? TIME_BITS : OUT_TIME_W;

    // chain taps
    logic                 w_ge    [DEPTH];
    logic                 w_valid [DEPTH];
    logic [TIME_BITS-1:0] w_time  [DEPTH];
    logic [PID_W-1:0]     w_pid   [DEPTH];
    logic                 w_core  [DEPTH];

    logic [CW-1:0]         r_count, n_count;
    logic                  w_acc, w_full, w_empty;
    t_cell_ctrl            w_ctrl;
    logic [XIW-1:0]        w_in_ext;
    logic [TIME_BITS-1:0]  w_new_time;
    logic [TIME_BITS-1:0]  w_sel_time;
    logic [PID_W-1:0]      w_sel_pid;
    logic [XOW-1:0]        w_out_ext;
    logic [EW-1:0]         w_cnt_ext;

    logic                  r_done;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [PID_W-1:0]      r_pid, n_pid;
    logic [OUT_TIME_W-1:0] r_time, n_time;
    logic [ENTRIES_W-1:0]  r_entries;
    logic                  r_empty;

    // every command completes in the cycle it is taken
    assign busy  = 1'b0;
    assign w_acc = start && !busy;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    // incoming time kept to TIME_BITS
    assign w_in_ext   = XIW'(i_event_time);
    assign w_new_time = w_in_ext[TIME_BITS-1:0];

    // control broadcast
    assign w_ctrl.ins  = w_acc && (i_func == FUNC_INSERT) && !w_full;
    assign w_ctrl.take = w_acc && (i_func == FUNC_TAKE) && !w_empty;
    assign w_ctrl.swap = w_valid[1] && (w_time[0] == w_time[1])
                         && !w_core[0] && w_core[1];

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                 w_p_ge, w_p_valid, w_p_core;
        logic [TIME_BITS-1:0] w_p_time;
        logic [PID_W-1:0]     w_p_pid;
        logic                 w_n_valid, w_n_core;
        logic [TIME_BITS-1:0] w_n_time;
        logic [PID_W-1:0]     w_n_pid;

        if (g == 0) begin : g_head
            assign w_p_ge    = 1'b0;
            assign w_p_valid = 1'b0;
            assign w_p_time  = '0;
            assign w_p_pid   = '0;
            assign w_p_core  = 1'b0;
        end else begin : g_mid
            assign w_p_ge    = w_ge[g-1];
            assign w_p_valid = w_valid[g-1];
            assign w_p_time  = w_time[g-1];
            assign w_p_pid   = w_pid[g-1];
            assign w_p_core  = w_core[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_n_valid = 1'b0;
            assign w_n_time  = '0;
            assign w_n_pid   = '0;
            assign w_n_core  = 1'b0;
        end else begin : g_body
            assign w_n_valid = w_valid[g+1];
            assign w_n_time  = w_time[g+1];
            assign w_n_pid   = w_pid[g+1];
            assign w_n_core  = w_core[g+1];
        end

        tevq_cell #(
            .IDX       (g),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_new_time   (w_new_time),
            .i_new_pid    (i_proc_id),
            .i_new_core   (i_is_core),
            .i_prev_ge    (w_p_ge),
            .i_prev_valid (w_p_valid),
            .i_prev_time  (w_p_time),
            .i_prev_pid   (w_p_pid),
            .i_prev_core  (w_p_core),
            .i_next_valid (w_n_valid),
            .i_next_time  (w_n_time),
            .i_next_pid   (w_n_pid),
            .i_next_core  (w_n_core),
            .o_ge         (w_ge[g]),
            .o_valid      (w_valid[g]),
            .o_time       (w_time[g]),
            .o_pid        (w_pid[g]),
            .o_core       (w_core[g])
        );
    end

    // pick the event being taken
    assign w_sel_time = w_ctrl.swap ? w_time[1] : w_time[0];
    assign w_sel_pid  = w_ctrl.swap ? w_pid[1]  : w_pid[0];
    assign w_out_ext  = XOW'(w_sel_time);

    // result word and next count
    always_comb begin
        n_count  = r_count;
        n_status = ST_INSERTED;
        n_pid    = '0;
        n_time   = '0;
        case (i_func)
            FUNC_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_INSERTED;
                    n_count  = r_count + CW'(1);
                end
            end
            FUNC_TAKE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_status = ST_TAKEN;
                    n_pid    = w_sel_pid;
                    n_time   = w_out_ext[OUT_TIME_W-1:0];
                    n_count  = r_count - CW'(1);
                end
            end
            default: begin
                n_status = ST_INSERTED;
            end
        endcase
    end

    assign w_cnt_ext = EW'(n_count);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= w_acc;
            if (w_acc) begin
                r_count <= n_count;
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status  <= n_status;
            r_pid     <= n_pid;
            r_time    <= n_time;
            r_entries <= w_cnt_ext[ENTRIES_W-1:0];
            r_empty   <= (n_count == '0);
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_out_proc_id = r_pid;
    assign o_out_time    = r_time;
    assign o_entries     = r_entries;
    assign o_list_empty  = r_empty;

    // count agrees with the head and tail valid bits
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == !w_valid[0])
        else $error("count and head valid disagree");

    a_full_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(DEPTH)) == w_valid[DEPTH-1])
        else $error("count and tail valid disagree");

    // front of the chain stays sorted
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[1] |-> (w_time[0] <= w_time[1]))
        else $error("chain head out of order");

    // every accepted command gives one result word next cycle
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> o_done)
        else $error("missing result strobe");

    // a successful take shortens the queue by one
    a_take_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.take |=> (r_count == $past(r_count) - CW'(1)))
        else $error("take did not decrement count");

endmodule

[sim/timed_event_priority_queue_test.sv]
// timed_event_priority_queue_test: self-checking bench for the sorted event queue
// depends on tevq_pkg and timed_event_priority_queue; predicts every result word
// in a behavioral copy of the queue and compares each strobed result with it

`timescale 1ns / 100ps

module timed_event_priority_queue_test;
    import tevq_pkg::*;

    localparam int QDEPTH      = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 100000;
    localparam int SETTLE      = 8;

    // one stored event of the predicted queue
    typedef struct packed {
        logic [PID_W-1:0]     pid;
        logic [IN_TIME_W-1:0] stamp;
        logic                 core;
    } t_event;

    // one result word
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [PID_W-1:0]      pid;
        logic [OUT_TIME_W-1:0] stamp;
        logic [ENTRIES_W-1:0]  entries;
        logic                  list_empty;
    } t_result;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    logic                  i_func       = FUNC_INSERT;
    logic [PID_W-1:0]      i_proc_id    = '0;
    logic [IN_TIME_W-1:0]  i_event_time = '0;
    logic                  i_is_core    = 1'b0;
    logic                  o_done;
    logic [STATUS_W-1:0]   o_status;
    logic [PID_W-1:0]      o_out_proc_id;
    logic [OUT_TIME_W-1:0] o_out_time;
    logic [ENTRIES_W-1:0]  o_entries;
    logic                  o_list_empty;

    // predicted queue contents and expected result words
    t_event      queue_store [QDEPTH];
    int unsigned queue_count = 0;
    t_result     pending_results[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned idle_pct       = 0;

    timed_event_priority_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_proc_id     (i_proc_id),
        .i_event_time  (i_event_time),
        .i_is_core     (i_is_core),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_out_proc_id (o_out_proc_id),
        .o_out_time    (o_out_time),
        .o_entries     (o_entries),
        .o_list_empty  (o_list_empty)
    );

    // 20 ns clock
    always #10 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // apply one command to the predicted queue and return its result word
    function automatic t_result next_queue_result(input logic fn,
                                                  input logic [PID_W-1:0] pid,
                                                  input logic [IN_TIME_W-1:0] stamp,
                                                  input logic core);
        t_result     res;
        int unsigned pos;
        int unsigned i;
        res = '0;
        if (fn == FUNC_INSERT) begin
            if (queue_count >= QDEPTH) begin
                res.status = ST_FULL;
            end else begin
                // new event goes ahead of every event with time >= its own
                pos = 0;
                while (pos < queue_count && queue_store[pos].stamp < stamp)
                    pos++;
                for (i = queue_count; i > pos; i--)
                    queue_store[i] = queue_store[i-1];
                queue_store[pos] = '{pid: pid, stamp: stamp, core: core};
                queue_count++;
                res.status = ST_INSERTED;
            end
        end else begin
            if (queue_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                // equal front times: a core event second goes ahead of a plain first
                pos = 0;
                if (queue_count >= 2 && queue_store[0].stamp == queue_store[1].stamp &&
                    !queue_store[0].core && queue_store[1].core)
                    pos = 1;
                res.pid   = queue_store[pos].pid;
                res.stamp = queue_store[pos].stamp;
                for (i = pos; i + 1 < queue_count; i++)
                    queue_store[i] = queue_store[i+1];
                queue_count--;
                res.status = ST_TAKEN;
            end
        end
        res.entries    = ENTRIES_W'(queue_count);
        res.list_empty = (queue_count == 0);
        return res;
    endfunction

    // send one command word, with random idle cycles ahead of it
    task automatic send_word(input logic fn, input logic [PID_W-1:0] pid,
                             input logic [IN_TIME_W-1:0] stamp, input logic core);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start        <= 1'b1;
        i_func       <= fn;
        i_proc_id    <= pid;
        i_event_time <= stamp;
        i_is_core    <= core;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(next_queue_result(fn, pid, stamp, core));
    endtask

    task automatic insert_event(input logic [PID_W-1:0] pid,
                                input logic [IN_TIME_W-1:0] stamp, input logic core);
        send_word(FUNC_INSERT, pid, stamp, core);
    endtask

    task automatic take_event();
        send_word(FUNC_TAKE, PID_W'($urandom), IN_TIME_W'($urandom), 1'($urandom));
    endtask

    // stop sending and wait for every expected word
    task automatic wait_results_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // compare each strobed result word with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result want;
        t_result got;
        if (i_rst_n && o_done === 1'b1) begin
            got = '{status: o_status, pid: o_out_proc_id, stamp: o_out_time,
                    entries: o_entries, list_empty: o_list_empty};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result word with none expected: status %0d pid %h",
                             $realtime, got.status, got.pid);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.pid !== want.pid ||
                    got.stamp !== want.stamp || got.entries !== want.entries ||
                    got.list_empty !== want.list_empty) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: expected status %0d pid %h time %h entries %0d ",
                                  "empty %b, got status %0d pid %h time %h entries %0d ",
                                  "empty %b"}, $realtime,
                                 want.status, want.pid, want.stamp, want.entries,
                                 want.list_empty, got.status, got.pid, got.stamp,
                                 got.entries, got.list_empty);
                end
            end
        end
    end

    // take from an empty queue right after reset
    task automatic test_take_on_empty();
        take_event();
        take_event();
    endtask

    // ordering, extremes of the fields and the core tie rule
    task automatic test_ordering_and_ties();
        insert_event(8'h00, 32'h0000_0000, 1'b0);
        insert_event(8'hFF, 32'hFFFF_FFFF, 1'b1);
        insert_event(8'h11, 32'h0005_0000, 1'b1);
        insert_event(8'h22, 32'h0005_0000, 1'b0);
        take_event();   // earliest time
        take_event();   // plain first, core second: core one leaves
        take_event();
        take_event();
        take_event();   // empty again
        // both core at equal time: front leaves
        insert_event(8'h33, 32'h0009_8000, 1'b1);
        insert_event(8'h44, 32'h0009_8000, 1'b1);
        take_event();
        insert_event(8'h55, 32'h0009_8000, 1'b0);
        take_event();
        take_event();
        // neither core: newest leaves first
        insert_event(8'h66, 32'h0007_0000, 1'b0);
        insert_event(8'h77, 32'h0007_0000, 1'b0);
        take_event();
        take_event();
        // core first, plain second: no swap
        insert_event(8'hAA, 32'h0004_0001, 1'b0);
        insert_event(8'hBB, 32'h0004_0001, 1'b1);
        take_event();
        take_event();
    endtask

    // fill the queue to the top, then overflow it
    task automatic test_fill_and_overflow();
        while (queue_count < QDEPTH)
            insert_event(PID_W'($urandom), IN_TIME_W'($urandom_range(0, 15)),
                         1'($urandom));
        insert_event(8'hFF, 32'h0000_0000, 1'b1);
        insert_event(8'h00, 32'hFFFF_FFFF, 1'b0);
        take_event();
        insert_event(PID_W'($urandom), IN_TIME_W'($urandom_range(0, 15)), 1'b1);
        insert_event(PID_W'($urandom), IN_TIME_W'($urandom_range(0, 15)), 1'b0);
        repeat (3) take_event();
    endtask

    // random traffic leaning alternately toward filling and draining
    task automatic test_random_traffic(input int unsigned n_words, input int unsigned pct);
        logic                 lean_insert;
        logic [IN_TIME_W-1:0] stamp;
        int unsigned          k;
        idle_pct    = pct;
        lean_insert = 1'b1;
        for (k = 0; k < n_words; k++) begin
            if (k % 80 == 79)
                lean_insert = ~lean_insert;
            // few distinct times to force ties, else full range and extremes
            case ($urandom_range(3))
                0: stamp = IN_TIME_W'($urandom_range(0, 7));
                1: stamp = IN_TIME_W'($urandom);
                2: stamp = {16'($urandom_range(0, 3)), 16'h8000};
                default: stamp = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            endcase
            if ($urandom_range(99) < (lean_insert ? 70 : 30))
                insert_event(PID_W'($urandom), stamp, 1'($urandom));
            else
                take_event();
        end
    endtask

    // test sequence
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_take_on_empty();
        test_ordering_and_ties();
        test_fill_and_overflow();
        wait_results_drained();
        test_random_traffic(480, 0);
        wait_results_drained();
        test_random_traffic(450, 58);
        wait_results_drained();
        test_random_traffic(450, 16);

        wait_results_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
